// ===== rtl/core/spd_pkg.sv =====
// Types and constants shared by the space packet deframer modules.
package spd_pkg;

  localparam int unsigned DataW     = 8;
  localparam int unsigned WordW     = 16;
  localparam int unsigned LeftW     = 17;

  localparam logic [2:0] HDR_LAST_POS = 3'd5;

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_PAYLOAD,
    MODE_DISCARD
  } mode_t;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SHORT     = 2'd1;
  localparam logic [1:0] STATUS_VERSION   = 2'd2;
  localparam logic [1:0] STATUS_TOO_LONG  = 2'd3;

  localparam logic CFG_EXPECTED_VERSION = 1'b0;
  localparam logic CFG_MAX_LENGTH       = 1'b1;

  localparam logic [15:0] MAX_LENGTH_RESET = 16'd1024;

  typedef struct packed {
    logic [2:0]       pos;
    logic [WordW-1:0] ident;
    logic [WordW-1:0] sequence_w;
    logic [WordW-1:0] length_w;
    logic [LeftW-1:0] left;
    mode_t            mode;
  } parse_state_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       kind;
    logic [1:0]       status;
    logic [2:0]       version;
    logic             packet_type;
    logic             secondary_flag;
    logic [10:0]      apid;
    logic [1:0]       group_flags;
    logic [13:0]      packet_count;
    logic [WordW-1:0] data_length;
    logic [DataW-1:0] payload_byte;
    logic             end_of_packet;
  } result_t;

endpackage

// ===== rtl/core/spd_step.sv =====
// Next-state and result logic for one received byte of the deframer.
module spd_step (
  input  spd_pkg::parse_state_t      cur,
  input  logic [spd_pkg::DataW-1:0]  data_byte,
  input  logic                       last_byte,
  input  logic [2:0]                 expected_version,
  input  logic [spd_pkg::WordW-1:0]  max_payload_length,
  output spd_pkg::parse_state_t      nxt,
  output spd_pkg::result_t           res
);

  logic [spd_pkg::LeftW-1:0] left_dec;
  logic [2:0]                ver;

  always_comb begin
    nxt      = cur;
    res      = '0;
    left_dec = (cur.left != '0) ? cur.left - spd_pkg::LeftW'(1) : cur.left;
    ver      = 3'd0;
    case (cur.mode)
      spd_pkg::MODE_PAYLOAD: begin
        res.valid         = 1'b1;
        res.kind          = spd_pkg::KIND_PAYLOAD;
        res.payload_byte  = data_byte;
        nxt.left          = left_dec;
        res.end_of_packet = last_byte || (left_dec == '0);
        if (last_byte) begin
          nxt.mode = spd_pkg::MODE_HEADER;
        end else if (left_dec == '0) begin
          nxt.mode = spd_pkg::MODE_DISCARD;
        end
      end
      spd_pkg::MODE_HEADER: begin
        case (cur.pos)
          3'd0: nxt.ident[7:0]       = data_byte;
          3'd1: nxt.ident[15:8]      = data_byte;
          3'd2: nxt.sequence_w[7:0]  = data_byte;
          3'd3: nxt.sequence_w[15:8] = data_byte;
          3'd4: nxt.length_w[7:0]    = data_byte;
          default: nxt.length_w[15:8] = data_byte;
        endcase
        ver = nxt.ident[15:13];
        if (cur.pos < spd_pkg::HDR_LAST_POS) begin
          if (last_byte) begin
            nxt.pos           = 3'd0;
            res.valid         = 1'b1;
            res.kind          = spd_pkg::KIND_ERROR;
            res.status        = spd_pkg::STATUS_SHORT;
            res.end_of_packet = 1'b1;
          end else begin
            nxt.pos = cur.pos + 3'd1;
          end
        end else begin
          nxt.pos   = 3'd0;
          res.valid = 1'b1;
          if (ver != expected_version || nxt.length_w > max_payload_length) begin
            res.kind          = spd_pkg::KIND_ERROR;
            res.status        = (ver != expected_version) ? spd_pkg::STATUS_VERSION
                                                          : spd_pkg::STATUS_TOO_LONG;
            res.end_of_packet = 1'b1;
            nxt.mode          = last_byte ? spd_pkg::MODE_HEADER : spd_pkg::MODE_DISCARD;
          end else begin
            res.kind           = spd_pkg::KIND_HEADER;
            res.status         = spd_pkg::STATUS_OK;
            res.version        = ver;
            res.packet_type    = nxt.ident[11];
            res.secondary_flag = nxt.ident[10];
            res.apid           = nxt.ident[10:0];
            res.group_flags    = nxt.sequence_w[15:14];
            res.packet_count   = nxt.sequence_w[13:0];
            res.data_length    = nxt.length_w;
            if (nxt.length_w == '0) begin
              nxt.left          = '0;
              res.end_of_packet = 1'b1;
              nxt.mode          = last_byte ? spd_pkg::MODE_HEADER : spd_pkg::MODE_DISCARD;
            end else begin
              nxt.left          = {1'b0, nxt.length_w} + spd_pkg::LeftW'(1);
              res.end_of_packet = last_byte;
              nxt.mode          = last_byte ? spd_pkg::MODE_HEADER : spd_pkg::MODE_PAYLOAD;
            end
          end
        end
      end
      default: begin
        if (last_byte) begin
          nxt.mode = spd_pkg::MODE_HEADER;
        end
      end
    endcase
  end

endmodule

// ===== rtl/core/space_packet_deframer_core.sv =====
// Top level of the space packet primary header deframer.
// The deframer takes one byte of a received buffer per word, with tlast on the
// final byte, and accepts a new word in every cycle that in_tready is high.
// Each accepted byte is decoded in the same cycle against the parser state and
// its result, if any, is held in a single output register; a result appears
// in the cycle after its byte and the input stays ready whenever that register
// is empty or is being taken. The sixth header byte yields a decoded header or
// an error (a short error if tlast comes first), payload bytes follow one for
// one, and bytes after an error or after the payload are dropped until tlast.
module space_packet_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], version[4:2], packet_type[5], secondary_flag[6],
  // apid[17:7], group_flags[19:18], packet_count[33:20], data_length[49:34],
  // payload_byte[57:50], zero[63:58]
  output logic [63:0] out_tdata,
  output logic [1:0]  out_tuser,  // result_kind[1:0]
  output logic        out_tlast,  // end_of_packet
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  spd_pkg::parse_state_t state_r, state_nxt;
  spd_pkg::result_t      res_nxt, res_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [2:0]            exp_ver_r;
  logic [15:0]           max_len_r;
  logic                  in_acc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  spd_step u_step (
    .cur                (state_r),
    .data_byte          (in_tdata),
    .last_byte          (in_tlast),
    .expected_version   (exp_ver_r),
    .max_payload_length (max_len_r),
    .nxt                (state_nxt),
    .res                (res_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (in_acc) begin
      out_valid_nxt = res_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.pos        <= 3'd0;
      state_r.ident      <= '0;
      state_r.sequence_w <= '0;
      state_r.length_w   <= '0;
      state_r.left       <= '0;
      state_r.mode       <= spd_pkg::MODE_HEADER;
      out_valid_r        <= 1'b0;
      exp_ver_r          <= 3'd0;
      max_len_r          <= spd_pkg::MAX_LENGTH_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        state_r <= state_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          spd_pkg::CFG_EXPECTED_VERSION: exp_ver_r <= cfg_wdata[2:0];
          spd_pkg::CFG_MAX_LENGTH:       max_len_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.end_of_packet;
  assign out_tdata  = {6'd0, res_r.payload_byte, res_r.data_length, res_r.packet_count,
                       res_r.group_flags, res_r.apid, res_r.secondary_flag,
                       res_r.packet_type, res_r.version, res_r.status};

  // Every error result closes its buffer.
  a_error_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.kind == spd_pkg::KIND_ERROR |-> res_r.end_of_packet)
    else $error("error result without end of packet");

  // Payload mode always has bytes still to pass.
  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.mode == spd_pkg::MODE_PAYLOAD |-> state_r.left != '0)
    else $error("payload mode with nothing left");

  // The header byte index never passes the sixth byte.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pos <= spd_pkg::HDR_LAST_POS)
    else $error("header position out of range");

  // A byte marked last leaves the parser at the start of a new header.
  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> state_r.mode == spd_pkg::MODE_HEADER && state_r.pos == 3'd0)
    else $error("parser not restarted after last byte");

endmodule

// ===== tb/space_packet_deframer_checker.sv =====
// Checker for the space packet deframer: predicts every result word and compares it.
module space_packet_deframer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          mismatch_count,
  output int          outstanding
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [2:0]  version;
    logic        packet_type;
    logic        secondary_flag;
    logic [10:0] apid;
    logic [1:0]  group_flags;
    logic [13:0] packet_count;
    logic [15:0] data_length;
    logic [7:0]  payload_byte;
    logic        end_of_packet;
  } frame_result_t;

  frame_result_t decoded_q[$];

  logic [2:0]      hdr_pos;
  logic [15:0]     ident_w;
  logic [15:0]     seq_w;
  logic [15:0]     len_w;
  logic [16:0]     bytes_left;
  spd_pkg::mode_t  mode;
  logic [2:0]      want_version;
  logic [15:0]     length_limit;

  task automatic deframe_byte(input logic [7:0] b, input logic last, output bit has,
                              output frame_result_t res);
    res = '0;
    has = 1'b0;
    if (mode == spd_pkg::MODE_PAYLOAD) begin
      res.kind = spd_pkg::KIND_PAYLOAD;
      res.payload_byte = b;
      if (bytes_left != 0) bytes_left = bytes_left - 17'd1;
      res.end_of_packet = last || (bytes_left == 0);
      if (last) mode = spd_pkg::MODE_HEADER;
      else if (bytes_left == 0) mode = spd_pkg::MODE_DISCARD;
      has = 1'b1;
      return;
    end
    if (mode != spd_pkg::MODE_HEADER) begin
      if (last) mode = spd_pkg::MODE_HEADER;
      return;
    end
    case (hdr_pos)
      3'd0: ident_w[7:0] = b;
      3'd1: ident_w[15:8] = b;
      3'd2: seq_w[7:0] = b;
      3'd3: seq_w[15:8] = b;
      3'd4: len_w[7:0] = b;
      default: len_w[15:8] = b;
    endcase
    if (hdr_pos < spd_pkg::HDR_LAST_POS) begin
      if (last) begin
        hdr_pos = 3'd0;
        res.kind = spd_pkg::KIND_ERROR;
        res.status = spd_pkg::STATUS_SHORT;
        res.end_of_packet = 1'b1;
        has = 1'b1;
      end else begin
        hdr_pos = hdr_pos + 3'd1;
      end
      return;
    end
    hdr_pos = 3'd0;
    has = 1'b1;
    if (ident_w[15:13] != want_version || len_w > length_limit) begin
      res.kind = spd_pkg::KIND_ERROR;
      res.status = (ident_w[15:13] != want_version) ? spd_pkg::STATUS_VERSION
                                                    : spd_pkg::STATUS_TOO_LONG;
      res.end_of_packet = 1'b1;
      mode = last ? spd_pkg::MODE_HEADER : spd_pkg::MODE_DISCARD;
      return;
    end
    res.kind = spd_pkg::KIND_HEADER;
    res.status = spd_pkg::STATUS_OK;
    res.version = ident_w[15:13];
    res.packet_type = ident_w[11];
    res.secondary_flag = ident_w[10];
    res.apid = ident_w[10:0];
    res.group_flags = seq_w[15:14];
    res.packet_count = seq_w[13:0];
    res.data_length = len_w;
    if (len_w == 0) begin
      bytes_left = '0;
      res.end_of_packet = 1'b1;
      mode = last ? spd_pkg::MODE_HEADER : spd_pkg::MODE_DISCARD;
    end else begin
      bytes_left = {1'b0, len_w} + 17'd1;
      res.end_of_packet = last;
      mode = last ? spd_pkg::MODE_HEADER : spd_pkg::MODE_PAYLOAD;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    frame_result_t res;
    frame_result_t want;
    bit has;
    if (!rst_n) begin
      hdr_pos = '0;
      ident_w = '0;
      seq_w = '0;
      len_w = '0;
      bytes_left = '0;
      mode = spd_pkg::MODE_HEADER;
      want_version = '0;
      length_limit = spd_pkg::MAX_LENGTH_RESET;
      decoded_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          spd_pkg::CFG_EXPECTED_VERSION: want_version = cfg_wdata[2:0];
          spd_pkg::CFG_MAX_LENGTH: length_limit = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          $error("result word with no result outstanding: tuser %0h tdata %0h",
                 out_tuser, out_tdata);
          mismatch_count++;
        end else begin
          want = decoded_q.pop_front();
          check_field("result_kind", 16'(want.kind), 16'(out_tuser));
          check_field("status", 16'(want.status), 16'(out_tdata[1:0]));
          check_field("version", 16'(want.version), 16'(out_tdata[4:2]));
          check_field("packet_type", 16'(want.packet_type), 16'(out_tdata[5]));
          check_field("secondary_flag", 16'(want.secondary_flag), 16'(out_tdata[6]));
          check_field("apid", 16'(want.apid), 16'(out_tdata[17:7]));
          check_field("group_flags", 16'(want.group_flags), 16'(out_tdata[19:18]));
          check_field("packet_count", 16'(want.packet_count), 16'(out_tdata[33:20]));
          check_field("data_length", want.data_length, out_tdata[49:34]);
          check_field("payload_byte", 16'(want.payload_byte), 16'(out_tdata[57:50]));
          check_field("end_of_packet", 16'(want.end_of_packet), 16'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) begin
        deframe_byte(in_tdata, in_tlast, has, res);
        if (has) decoded_q.push_back(res);
      end
    end
    outstanding = decoded_q.size();
  end

endmodule

// ===== tb/space_packet_deframer_core_test.sv =====
// Test top for the space packet deframer: drives buffers and configuration, gives the verdict.
module space_packet_deframer_core_test;

  localparam int QuietLimit = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;
  int          mismatch_count;
  int          outstanding;

  int          burst_left = 0;
  int          bytes_sent = 0;
  int          quiet_cycles = 0;
  int          stall_style = 0;
  int          stall_run = 0;
  int          ready_tick = 0;
  logic [2:0]  cur_ver = 3'd0;
  int          cur_max = 1024;

  space_packet_deframer_core u_top (.*);

  space_packet_deframer_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_run = $urandom_range(20, 200);
    end
    stall_run--;
    ready_tick++;
    case (stall_style)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ((ready_tick % 4) != 3);
      default: out_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        in_tdata <= 8'($urandom);
        in_tlast <= 1'($urandom);
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_frame(input logic [15:0] ident, input logic [15:0] seqw,
                            input logic [15:0] lenw, input int total);
    logic [7:0] b;
    for (int i = 0; i < total; i++) begin
      case (i)
        0: b = ident[7:0];
        1: b = ident[15:8];
        2: b = seqw[7:0];
        3: b = seqw[15:8];
        4: b = lenw[7:0];
        5: b = lenw[15:8];
        default: b = 8'($urandom);
      endcase
      push_byte(b, i == total - 1);
      bytes_sent++;
    end
  endtask

  task automatic random_frame();
    int pick;
    int total;
    int cap;
    logic [15:0] ident;
    logic [15:0] seqw;
    logic [15:0] lenw;
    ident = 16'($urandom);
    seqw = 16'($urandom);
    lenw = 16'($urandom);
    ident[15:13] = cur_ver;
    pick = $urandom_range(0, 99);
    if (pick < 68) begin
      cap = (cur_max < 12) ? cur_max : 12;
      if ($urandom_range(0, 9) == 0) cap = (cur_max < 48) ? cur_max : 48;
      lenw = 16'($urandom_range(0, cap));
      total = 6 + ((lenw == 0) ? 0 : lenw + 1);
      case ($urandom_range(0, 4))
        0: total = total + $urandom_range(1, 4);
        1: begin
          if (lenw != 0) total = $urandom_range(7, total);
        end
        default: ;
      endcase
    end else if (pick < 78) begin
      if (cur_max < 65535) lenw = 16'($urandom_range(cur_max + 1, 65535));
      total = $urandom_range(6, 10);
    end else if (pick < 86) begin
      ident[15:13] = cur_ver + 3'($urandom_range(1, 7));
      total = $urandom_range(6, 10);
    end else if (pick < 93) begin
      total = $urandom_range(1, 5);
    end else begin
      ident = 16'($urandom);
      total = $urandom_range(1, 14);
    end
    send_frame(ident, seqw, lenw, total);
  endtask

  task automatic configure(input logic [2:0] ver, input logic [15:0] limit);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= spd_pkg::CFG_EXPECTED_VERSION;
    cfg_wdata <= {13'($urandom), ver};
    @(negedge clk);
    cfg_index <= spd_pkg::CFG_MAX_LENGTH;
    cfg_wdata <= limit;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= 16'($urandom);
    cur_ver = ver;
    cur_max = int'(limit);
    burst_left = 0;
  endtask

  initial begin
    int target;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: version 0 expected, length limit 1024.
    send_frame(16'h1234, 16'h0000, 16'h0000, 1);
    send_frame(16'h07FF, 16'hFFFF, 16'hFFFF, 5);
    send_frame(16'h1FFF, 16'hFFFF, 16'h0000, 7);
    send_frame(16'hE000, 16'h0000, 16'h0000, 6);
    send_frame(16'h0000, 16'h0000, 16'h0401, 7);
    send_frame(16'h0800, 16'hC000, 16'h0002, 8);
    send_frame(16'h0400, 16'h3FFF, 16'h0400, 6);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: configure(3'd7, 16'hFFFF);
        1: configure(3'd0, 16'h0000);
        2: configure(3'd5, 16'd20);
        3: configure(3'($urandom), 16'($urandom_range(1, 64)));
        4: configure(3'($urandom), spd_pkg::MAX_LENGTH_RESET);
        default: configure(3'd2, 16'd1);
      endcase
      target = bytes_sent + 236;
      while (bytes_sent < target) random_frame();
    end

    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
